/* design/rsp_packet_deframer_macros.svh */
// assertion macros for the rsp packet deframer
// used by rsp_packet_deframer.sv, no other dependencies
`ifndef RSP_PACKET_DEFRAMER_MACROS_SVH
`define RSP_PACKET_DEFRAMER_MACROS_SVH

// antecedent implies consequent in the same cycle, off during reset
`define RPD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition never holds, off during reset
`define RPD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

/* design/rpd_pkg.sv */
// shared types and constants of the rsp packet deframer
// no dependencies
package rpd_pkg;

  // framing and reply characters
  localparam logic [7:0] CHAR_START = 8'h24;  // '$'
  localparam logic [7:0] CHAR_CSUM  = 8'h23;  // '#'
  localparam logic [7:0] CHAR_ACK   = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_NAK   = 8'h2D;  // '-'

  localparam int unsigned LenW = 9;

  localparam logic [LenW-1:0] MAX_LEN_RESET = 9'd256;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_ACCEPT   = 3'd1,
    KIND_MISMATCH = 3'd2,
    KIND_OVERFLOW = 3'd3,
    KIND_BADHEX   = 3'd4,
    KIND_ABORT    = 3'd5
  } kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       link_error;
  } rx_item_t;

  typedef struct packed {
    logic [2:0]      result_kind;
    logic [7:0]      payload_byte;
    logic [LenW-1:0] packet_length;
    logic            send_reply;
    logic [7:0]      reply_byte;
    logic            end_of_packet;
  } result_t;

endpackage

/* design/rpd_engine.sv */
// per-byte framing state machine: phase, running sum, count, checksum nibble
// depends on rpd_pkg
module rpd_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  rpd_pkg::rx_item_t         item_i,
  input  logic [rpd_pkg::LenW-1:0]  limit_i,
  output logic                      res_valid_o,
  output rpd_pkg::result_t          res_o
);

  typedef enum logic [1:0] {
    PhIdle,
    PhData,
    PhHex1,
    PhHex2
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [7:0]                sum_q, sum_d;
  logic [rpd_pkg::LenW-1:0]  count_q, count_d;
  logic [3:0]                hi_q, hi_d;
  logic [4:0]                hex_val;

  // digit value, bit 4 set when not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      v = 5'(c[3:0]) + 5'd9;
    end
    return v;
  endfunction

  // status result that closes the packet
  function automatic rpd_pkg::result_t status(input logic [2:0] kind,
                                              input logic [7:0] reply,
                                              input logic [rpd_pkg::LenW-1:0] len);
    rpd_pkg::result_t r;
    r.result_kind   = kind;
    r.payload_byte  = 8'h00;
    r.packet_length = len;
    r.send_reply    = (reply != 8'h00);
    r.reply_byte    = reply;
    r.end_of_packet = 1'b1;
    return r;
  endfunction

  assign hex_val = hex_value(item_i.rx_byte);

  always_comb begin
    phase_d     = phase_q;
    sum_d       = sum_q;
    count_d     = count_q;
    hi_d        = hi_q;
    res_valid_o = 1'b0;
    res_o       = status(rpd_pkg::KIND_ABORT, 8'h00, count_q);
    if (phase_q == PhIdle) begin
      if (!item_i.link_error && item_i.rx_byte == rpd_pkg::CHAR_START) begin
        phase_d = PhData;
        sum_d   = '0;
        count_d = '0;
        hi_d    = '0;
      end
    end else if (item_i.link_error) begin
      res_valid_o = 1'b1;
      res_o       = status(rpd_pkg::KIND_ABORT, 8'h00, count_q);
      phase_d     = PhIdle;
    end else if (phase_q == PhData) begin
      if (item_i.rx_byte == rpd_pkg::CHAR_CSUM) begin
        phase_d = PhHex1;
      end else if (count_q >= limit_i) begin
        res_valid_o = 1'b1;
        res_o       = status(rpd_pkg::KIND_OVERFLOW, 8'h00, count_q);
        phase_d     = PhIdle;
      end else begin
        sum_d             = sum_q + item_i.rx_byte;
        count_d           = count_q + 1'b1;
        res_valid_o       = 1'b1;
        res_o.result_kind = rpd_pkg::KIND_PAYLOAD;
        res_o.payload_byte  = item_i.rx_byte;
        res_o.packet_length = count_d;
        res_o.send_reply    = 1'b0;
        res_o.reply_byte    = 8'h00;
        res_o.end_of_packet = 1'b0;
      end
    end else if (hex_val[4]) begin
      res_valid_o = 1'b1;
      res_o       = status(rpd_pkg::KIND_BADHEX, 8'h00, count_q);
      phase_d     = PhIdle;
    end else if (phase_q == PhHex1) begin
      hi_d    = hex_val[3:0];
      phase_d = PhHex2;
    end else begin
      res_valid_o = 1'b1;
      phase_d     = PhIdle;
      if ({hi_q, hex_val[3:0]} == sum_q) begin
        res_o = status(rpd_pkg::KIND_ACCEPT, rpd_pkg::CHAR_ACK, count_q);
      end else begin
        res_o = status(rpd_pkg::KIND_MISMATCH, rpd_pkg::CHAR_NAK, count_q);
      end
    end
    // a closed packet leaves clean state behind
    if (res_valid_o && res_o.end_of_packet) begin
      sum_d   = '0;
      count_d = '0;
      hi_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      sum_q   <= '0;
      count_q <= '0;
      hi_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      hi_q    <= hi_d;
    end
  end

endmodule

/* design/rsp_packet_deframer.sv */
// rsp packet deframer: input register, then result register; one byte per cycle
// sustained; the input register holds a byte while the framing logic sits between it
// and the result register, so the only bubble comes from a stalled result
// rst_ni clears phase, sum, count, both valid flags and sets max_len to 256
// top level, depends on rpd_pkg, rpd_engine and rsp_packet_deframer_macros.svh
`include "rsp_packet_deframer_macros.svh"

module rsp_packet_deframer #(
  parameter int unsigned MAX_PACKET = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration: max_len
  input  logic                      cfg_we_i,
  input  logic [rpd_pkg::LenW-1:0]  cfg_wdata_i,
  // received bytes
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  rpd_pkg::rx_item_t         in_item_i,
  // results
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output rpd_pkg::result_t          out_result_o
);

  // the count never exceeds max_len, so a cap above the field range changes nothing
  localparam int unsigned CapInt = (MAX_PACKET > 511) ? 511 : MAX_PACKET;
  localparam logic [rpd_pkg::LenW-1:0] CapLen = rpd_pkg::LenW'(CapInt);

  logic [rpd_pkg::LenW-1:0] max_len_q;
  logic [rpd_pkg::LenW-1:0] limit;

  logic              in_valid_q;
  rpd_pkg::rx_item_t in_q;

  logic              out_valid_q;
  rpd_pkg::result_t  out_q;

  logic              out_free;
  logic              advance;
  logic              res_valid;
  rpd_pkg::result_t  res;

  // config register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= rpd_pkg::MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // effective length limit, saturated at the build-time cap
  assign limit = (max_len_q > CapLen) ? CapLen : max_len_q;

  // result slot is free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;
  // the held byte moves through the framing logic whenever the slot is free
  assign advance  = in_valid_q && out_free;
  // input register refills in the same cycle it drains
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload register, loaded on an input transaction
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  rpd_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_q),
    .limit_i     (limit),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register; bytes with no result leave it empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

  // the input side only backs up behind a stalled result
  `RPD_ASSERT_IMPLIES(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled while result slot free")
  // replies only go with a checksum verdict
  `RPD_ASSERT_IMPLIES(a_reply_kind, clk_i, rst_ni, out_valid_o && out_result_o.send_reply, out_result_o.result_kind == rpd_pkg::KIND_ACCEPT || out_result_o.result_kind == rpd_pkg::KIND_MISMATCH, "reply on a kind without verdict")
  // a payload byte is always counted
  `RPD_ASSERT_NEVER(a_payload_len, clk_i, rst_ni, out_valid_o && out_result_o.result_kind == rpd_pkg::KIND_PAYLOAD && out_result_o.packet_length == '0, "payload result with zero length")

endmodule

/* dv/rsp_packet_deframer_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for rsp_packet_deframer: framed byte streams in, streamed payload
// and packet status out, every result compared against an in-bench model of the framing rules
// depends on rpd_pkg and the rsp_packet_deframer rtl
module rsp_packet_deframer_tb;

  localparam int unsigned MAX_PACKET   = 256;
  localparam int unsigned DRAIN_CYCLES = 8;     // input and result registers to pass, plus margin
  localparam int unsigned QUIET_LIMIT  = 1000;  // cycles with no transaction on either side
  localparam int unsigned RANDOM_ITEMS = 25;    // framed bytes per max_len setting
  localparam logic [4:0]  NOT_HEX      = 5'd16;
  localparam logic [7:0]  NO_REPLY     = 8'h00;

  // where the receiver stands inside a frame
  typedef enum logic [1:0] {
    WAIT_START,
    IN_PAYLOAD,
    CSUM_HI,
    CSUM_LO
  } frame_phase_e;

  // dut ports, all inputs known from time zero
  logic                     clk_i;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [rpd_pkg::LenW-1:0] cfg_wdata_i = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  rpd_pkg::rx_item_t        in_item_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  rpd_pkg::result_t         out_result_o;

  // model state, tracks the dut one accepted byte at a time
  logic [rpd_pkg::LenW-1:0] cur_max_len = rpd_pkg::MAX_LEN_RESET;
  frame_phase_e             frame_phase = WAIT_START;
  logic [7:0]               frame_sum   = '0;
  logic [rpd_pkg::LenW-1:0] frame_count = '0;
  logic [3:0]               csum_hi     = '0;

  rpd_pkg::rx_item_t        rx_queue[$];       // bytes waiting to be sent
  rpd_pkg::result_t         frame_results[$];  // results the dut still owes, oldest first
  rpd_pkg::result_t         oldest_due;

  int unsigned     mismatches     = 0;
  int unsigned     checked        = 0;
  int unsigned     accepted_items = 0;
  int unsigned     framed_items   = 0;
  int unsigned     settings_run   = 1;
  int unsigned     kind_seen[8];

  int unsigned     send_gap   = 0;
  int unsigned     send_calm  = 0;
  int unsigned     stall_left = 0;
  int unsigned     recv_calm  = 0;

  rsp_packet_deframer #(
    .MAX_PACKET(MAX_PACKET)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_result_o(out_result_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // model of the deframer
  // ---------------------------------------------------------------------------

  // value of a hex digit, NOT_HEX for any other character
  function automatic logic [4:0] hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    return NOT_HEX;
  endfunction

  // max_len saturates at the packet size the block was built for
  function automatic int unsigned length_limit();
    return (cur_max_len > MAX_PACKET) ? MAX_PACKET : int'(cur_max_len);
  endfunction

  // status result that ends the packet; length is the count before clearing
  function automatic void close_packet(rpd_pkg::kind_e kind, logic [7:0] reply);
    rpd_pkg::result_t r;
    r               = '0;
    r.result_kind   = kind;
    r.packet_length = frame_count;
    r.send_reply    = (kind == rpd_pkg::KIND_ACCEPT) || (kind == rpd_pkg::KIND_MISMATCH);
    r.reply_byte    = reply;
    r.end_of_packet = 1'b1;
    frame_results.push_back(r);
    frame_phase = WAIT_START;
    frame_sum   = '0;
    frame_count = '0;
    csum_hi     = '0;
  endfunction

  // one received byte: update the frame state, queue whatever result it causes
  function automatic void deframe(rpd_pkg::rx_item_t it);
    logic [4:0]       digit;
    rpd_pkg::result_t r;
    digit = hex_value(it.rx_byte);
    if (frame_phase == WAIT_START) begin
      // everything but a clean start character is line noise here
      if (!it.link_error && it.rx_byte == rpd_pkg::CHAR_START) begin
        frame_phase = IN_PAYLOAD;
        frame_sum   = '0;
        frame_count = '0;
        csum_hi     = '0;
      end
    end else if (it.link_error) begin
      close_packet(rpd_pkg::KIND_ABORT, NO_REPLY);
    end else if (frame_phase == IN_PAYLOAD) begin
      if (it.rx_byte == rpd_pkg::CHAR_CSUM) begin
        frame_phase = CSUM_HI;
      end else if (frame_count >= length_limit()) begin
        close_packet(rpd_pkg::KIND_OVERFLOW, NO_REPLY);
      end else begin
        frame_sum       = frame_sum + it.rx_byte;
        frame_count     = frame_count + 1'b1;
        r               = '0;
        r.result_kind   = rpd_pkg::KIND_PAYLOAD;
        r.payload_byte  = it.rx_byte;
        r.packet_length = frame_count;
        frame_results.push_back(r);
      end
    end else if (digit == NOT_HEX) begin
      // a bad first digit ends the packet too, the next byte is noise
      close_packet(rpd_pkg::KIND_BADHEX, NO_REPLY);
    end else if (frame_phase == CSUM_HI) begin
      csum_hi     = digit[3:0];
      frame_phase = CSUM_LO;
    end else if ({csum_hi, digit[3:0]} == frame_sum) begin
      close_packet(rpd_pkg::KIND_ACCEPT, rpd_pkg::CHAR_ACK);
    end else begin
      close_packet(rpd_pkg::KIND_MISMATCH, rpd_pkg::CHAR_NAK);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // idling on both sides
  // ---------------------------------------------------------------------------

  // mostly short gaps, a few long ones, now and then a stretch with none at all
  function automatic int unsigned pick_gap(inout int unsigned calm_left);
    int unsigned roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) calm_left = $urandom_range(20, 80);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // input driver: predicts each accepted transaction, then offers the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        deframe(in_item_i);
        accepted_items++;
      end
      // payload holds while stalled; otherwise idle a while or present the next byte
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (rx_queue.size() > 0) begin
          in_item_i  <= rx_queue.pop_front();
          in_valid_i <= 1'b1;
          send_gap = pick_gap(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                checked, name, got, want));
    end
  endtask

  // output monitor: compares each accepted result with the oldest one owed
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        checked++;
        if (frame_results.size() == 0) begin
          report_mismatch($sformatf("result %0d of kind %0d with nothing owed",
                                    checked, out_result_o.result_kind));
        end else begin
          oldest_due = frame_results.pop_front();
          check_field("result_kind", out_result_o.result_kind, oldest_due.result_kind);
          check_field("payload_byte", out_result_o.payload_byte, oldest_due.payload_byte);
          check_field("packet_length", out_result_o.packet_length,
                      oldest_due.packet_length);
          check_field("send_reply", out_result_o.send_reply, oldest_due.send_reply);
          check_field("reply_byte", out_result_o.reply_byte, oldest_due.reply_byte);
          check_field("end_of_packet", out_result_o.end_of_packet,
                      oldest_due.end_of_packet);
          if (oldest_due.end_of_packet) kind_seen[oldest_due.result_kind]++;
        end
      end
      // random backpressure on the result side
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = pick_gap(recv_calm);
        out_stall_i <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic push_byte(logic [7:0] b, logic err);
    rpd_pkg::rx_item_t it;
    it.rx_byte    = b;
    it.link_error = err;
    rx_queue.push_back(it);
    framed_items++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 4'd10) return "0" + n;
    return (upper ? "A" : "a") + n - 4'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom); while (hex_value(c) != NOT_HEX);
    return c;
  endfunction

  // payload length: mostly short, sometimes anywhere up to one past the limit
  function automatic int unsigned pick_len();
    int unsigned limit, roll;
    limit = length_limit();
    roll  = $urandom_range(0, 99);
    if (roll < 4) return $urandom_range(0, limit + 1);
    if (roll < 10 && limit <= 16) return limit + $urandom_range(0, 1);
    return $urandom_range(0, (limit + 1 < 8) ? limit + 1 : 8);
  endfunction

  // one frame with random content; most are well formed, the rest carry a wrong
  // checksum, a bad digit or a link error; a clean frame always has a good checksum
  task automatic send_packet(int unsigned len, bit clean);
    logic [7:0]        sum, b;
    logic [3:0]        hi, lo;
    int unsigned       fate, cut, n;
    rpd_pkg::rx_item_t it;
    fate = clean ? 0 : $urandom_range(0, 99);
    sum  = '0;
    // line noise ahead of the frame, never a clean start character
    repeat ($urandom_range(0, 2)) begin
      it.rx_byte    = 8'($urandom);
      it.link_error = 1'($urandom_range(0, 1));
      if (!it.link_error && it.rx_byte == rpd_pkg::CHAR_START) it.rx_byte = rpd_pkg::CHAR_CSUM;
      rx_queue.push_back(it);
    end
    push_byte(rpd_pkg::CHAR_START, 1'b0);
    // past the limit the first extra byte already ends the frame
    n   = (len > length_limit()) ? length_limit() + 1 : len;
    cut = $urandom_range(0, n + 2);
    for (int i = 0; i < n; i++) begin
      if (fate >= 93 && i == cut) begin
        push_byte(8'($urandom), 1'b1);
        return;
      end
      b = 8'($urandom);
      if (b == rpd_pkg::CHAR_CSUM) b = rpd_pkg::CHAR_START;  // a dollar is plain payload data
      push_byte(b, 1'b0);
      sum = sum + b;
    end
    if (len > length_limit()) return;
    if (fate >= 93 && cut == n) begin
      push_byte(8'($urandom), 1'b1);
      return;
    end
    push_byte(rpd_pkg::CHAR_CSUM, 1'b0);
    if (fate >= 93 && cut == n + 1) begin
      push_byte(8'($urandom), 1'b1);
      return;
    end
    {hi, lo} = sum;
    if (fate >= 70 && fate < 85) {hi, lo} = sum ^ 8'($urandom_range(1, 255));
    if (fate >= 85 && fate < 93 && cut[0]) begin
      push_byte(non_hex_char(), 1'b0);
      return;
    end
    push_byte(hex_char(hi, 1'($urandom_range(0, 1))), 1'b0);
    if (fate >= 93) begin
      push_byte(8'($urandom), 1'b1);
      return;
    end
    if (fate >= 85 && fate < 93) begin
      push_byte(non_hex_char(), 1'b0);
    end else begin
      push_byte(hex_char(lo, 1'($urandom_range(0, 1))), 1'b0);
    end
  endtask

  task automatic run_random();
    framed_items = 0;
    while (framed_items < RANDOM_ITEMS) send_packet(pick_len(), 1'b0);
  endtask

  // sender holds off until every byte is in and every result is out, then lets
  // the pipe settle; sampled on the falling edge so the rising edge has resolved
  task automatic wait_drained();
    do @(negedge clk_i);
    while (rx_queue.size() != 0 || in_valid_i || frame_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // new max_len, written only with the block idle
  task automatic retune(logic [rpd_pkg::LenW-1:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_max_len = value;
    settings_run++;
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed frames under the reset max_len
    push_byte(8'h00, 1'b0);                // idle noise
    push_byte(8'hFF, 1'b1);                // link error while waiting, no result
    push_byte(rpd_pkg::CHAR_START, 1'b1);  // start character with link error is not a start
    push_text("$#00");                     // empty payload accepted
    push_text("$$");                       // dollar as payload data
    push_byte(8'hFF, 1'b0);                // sum wraps to 0x23
    push_text("#23");
    push_text("$a#62");                    // checksum mismatch
    push_text("$#G0");                     // bad first digit, the '0' after it is noise
    push_text("$#a/");                     // bad second digit
    push_text("$x");
    push_byte(8'h00, 1'b1);                // link error inside the payload
    run_random();

    // frame of exactly the limit, then one byte over
    retune(9'd3);
    push_text("$abc#26");
    push_text("$abcd");
    run_random();

    // zero length limit: any payload byte overflows, empty frames still pass
    retune(9'd0);
    push_text("$a");
    push_text("$#00");
    run_random();

    // max_len above the build limit saturates at MAX_PACKET
    retune(9'd511);
    send_packet(MAX_PACKET + 1, 1'b1);
    run_random();

    retune(9'd1);
    push_text("$z#7a");
    run_random();

    // largest legal frame
    retune(rpd_pkg::MAX_LEN_RESET);
    send_packet(MAX_PACKET, 1'b1);
    run_random();

    retune(rpd_pkg::LenW'($urandom_range(2, 255)));
    run_random();

    wait_drained();
    $display("sent %0d bytes under %0d max_len settings (0, 1, 3, 256, 511 and random)",
             accepted_items, settings_run);
    $display("checked %0d results; packets %0d ok, %0d bad sum, %0d overflow, %0d bad digit,",
             checked, kind_seen[rpd_pkg::KIND_ACCEPT], kind_seen[rpd_pkg::KIND_MISMATCH],
             kind_seen[rpd_pkg::KIND_OVERFLOW], kind_seen[rpd_pkg::KIND_BADHEX]);
    $display("%0d aborted", kind_seen[rpd_pkg::KIND_ABORT]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog: ends a run that stops moving
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
